@@ src/m3inv_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the 3x3 matrix inverse core.
// No dependencies; imported by the top level and the testbench.
package m3inv_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// element index in row-major order, 0..8
	typedef logic [3:0] elem_idx_t;

	// cofactor (r,c) of the adjugate = m[PA]*m[PB] - m[QA]*m[QB]
	localparam elem_idx_t COF_PA [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam elem_idx_t COF_PB [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam elem_idx_t COF_QA [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam elem_idx_t COF_QB [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

endpackage

@@ src/mat3_inverse_adjugate_core.sv @@
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate and pipelined restoring division.
// Depends on m3inv_pkg and m3inv_div_step.
//
// Usage: drive m00..m22 (signed fixed point in the low ELEM_WIDTH bits) and
// pulse start; the matrix is taken at any edge with start high and busy low.
// busy never rises, so one matrix can enter every cycle.
// Results r00..r22 and singular appear for exactly one cycle with done high.
// Five stages form products, cofactors, determinant partial products, the
// determinant, and its magnitude with the singular test, and a sixth loads
// the divider lanes; ELEM_WIDTH stages each resolve one quotient bit in nine
// divider lanes sharing the determinant; a last stage saturates.
// Throughput is one matrix per cycle.
// singular_threshold is written through cfg_we/cfg_wdata, and is read by
// the singular test, so write it only while no matrix is in flight.
// Reset clears the valid bits and the threshold; the receiver cannot stall.
module mat3_inverse_adjugate_core #(
	parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic        done,
	output logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
	output logic        singular
);
	import m3inv_pkg::*;

	localparam int EW  = ELEM_WIDTH;
	localparam int CW  = 2 * EW;
	localparam int DW  = 3 * EW + 2;
	localparam int DMW = 3 * EW + 1;
	localparam int NW  = CW + 2 * FRAC_BITS;
	localparam int XW  = NW + DMW;
	localparam int TW  = (DMW > 64) ? DMW : 64;

	logic [63:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	logic signed [EW-1:0] me [9];
	assign me[0] = m00[EW-1:0];
	assign me[1] = m01[EW-1:0];
	assign me[2] = m02[EW-1:0];
	assign me[3] = m10[EW-1:0];
	assign me[4] = m11[EW-1:0];
	assign me[5] = m12[EW-1:0];
	assign me[6] = m20[EW-1:0];
	assign me[7] = m21[EW-1:0];
	assign me[8] = m22[EW-1:0];

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic vd_s [EW+1];
	logic done_q;

	// stage 1: cofactor products
	logic signed [CW-1:0] p_s1 [18];
	logic signed [EW-1:0] m0_s1 [3];
	// stage 2: cofactors
	logic signed [CW-1:0] cof_s2 [9];
	logic signed [EW-1:0] m0_s2 [3];
	// stage 3: determinant partial products
	logic signed [CW-1:0] ph_s3 [3];
	logic signed [CW:0]   pl_s3 [3];
	logic signed [CW-1:0] cof_s3 [9];
	// stage 4: determinant
	logic signed [DW-1:0] det_s4;
	logic signed [CW-1:0] cof_s4 [9];
	// stage 5: magnitudes, signs, singular test
	logic [DMW-1:0]       dmag_s5;
	logic                 sing_s5;
	logic [CW-1:0]        cmag_s5 [9];
	logic                 neg_s5 [9];

	// divider pipe, index 0 is stage 6
	logic [DMW-1:0] rem_s  [EW+1][9];
	logic [EW-1:0]  nq_s   [EW+1][9];
	logic           neg_s  [EW+1][9];
	logic           ovf_s  [EW+1][9];
	logic [DMW-1:0] dmag_s [EW];
	logic           sing_s [EW+1];

	logic signed [EW-1:0] res_q [9];
	logic                 sing_q;

	logic signed [DW-1:0] det_sum;
	logic [DMW-1:0]       dmag_c;
	logic [NW-1:0]        num_c [9];
	logic [XW-1:0]        rem0_c [9];
	logic                 ovf_c [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= vd_s[EW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= EW; k++) begin
				vd_s[k] <= 1'b0;
			end
		end else begin
			vd_s[0] <= v_s5;
			for (int k = 1; k <= EW; k++) begin
				vd_s[k] <= vd_s[k-1];
			end
		end
	end

	always_comb begin
		det_sum = '0;
		for (int k = 0; k < 3; k++) begin
			det_sum = det_sum + (DW'(ph_s3[k]) <<< EW) + DW'(pl_s3[k]);
		end
		dmag_c = det_s4[DW-1] ? DMW'(-det_s4) : DMW'(det_s4);
		for (int i = 0; i < 9; i++) begin
			num_c[i]  = NW'(cmag_s5[i]) << (2 * FRAC_BITS);
			rem0_c[i] = XW'(num_c[i]) >> EW;
			// quotient would not fit in EW bits
			ovf_c[i]  = XW'(num_c[i]) >= (XW'(dmag_s5) << EW);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			p_s1[2*i]   <= me[COF_PA[i]] * me[COF_PB[i]];
			p_s1[2*i+1] <= me[COF_QA[i]] * me[COF_QB[i]];
		end
		for (int k = 0; k < 3; k++) begin
			m0_s1[k] <= me[k];
		end

		for (int i = 0; i < 9; i++) begin
			cof_s2[i] <= p_s1[2*i] - p_s1[2*i+1];
		end
		m0_s2 <= m0_s1;

		// row-0 expansion: cofactors (0,0), (1,0), (2,0) split into halves
		for (int k = 0; k < 3; k++) begin
			ph_s3[k] <= m0_s2[k] * $signed(cof_s2[3*k][CW-1:EW]);
			pl_s3[k] <= m0_s2[k] * $signed({1'b0, cof_s2[3*k][EW-1:0]});
		end
		cof_s3 <= cof_s2;

		det_s4 <= det_sum;
		cof_s4 <= cof_s3;

		dmag_s5 <= dmag_c;
		sing_s5 <= (TW'(dmag_c) <= TW'(thr_q));
		for (int i = 0; i < 9; i++) begin
			cmag_s5[i] <= cof_s4[i][CW-1] ? CW'(-cof_s4[i]) : CW'(cof_s4[i]);
			neg_s5[i]  <= cof_s4[i][CW-1] ^ det_s4[DW-1];
		end

		for (int i = 0; i < 9; i++) begin
			rem_s[0][i] <= rem0_c[i][DMW-1:0];
			nq_s[0][i]  <= num_c[i][EW-1:0];
			neg_s[0][i] <= neg_s5[i];
			ovf_s[0][i] <= ovf_c[i];
		end
		dmag_s[0] <= dmag_s5;
		sing_s[0] <= sing_s5;

		for (int k = 1; k <= EW; k++) begin
			neg_s[k]  <= neg_s[k-1];
			ovf_s[k]  <= ovf_s[k-1];
			sing_s[k] <= sing_s[k-1];
		end
		for (int k = 1; k < EW; k++) begin
			dmag_s[k] <= dmag_s[k-1];
		end
	end

	genvar gk, gi;
	generate
		for (gk = 0; gk < EW; gk++) begin : g_stage
			for (gi = 0; gi < 9; gi++) begin : g_lane
				m3inv_div_step #(
					.DMW(DMW),
					.EW (EW)
				) u_step (
					.clk   (clk),
					.rem_i (rem_s[gk][gi]),
					.nq_i  (nq_s[gk][gi]),
					.dmag_i(dmag_s[gk]),
					.rem_o (rem_s[gk+1][gi]),
					.nq_o  (nq_s[gk+1][gi])
				);
			end
		end
	endgenerate

	// saturate, apply sign, zero on singular
	logic [EW:0]          qmag_c [9];
	logic signed [EW:0]   qsgn_c [9];
	localparam logic [EW:0] POS_LIM = (EW+1)'((64'd1 << (EW - 1)) - 64'd1);
	localparam logic [EW:0] NEG_LIM = (EW+1)'(64'd1 << (EW - 1));

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			qmag_c[i] = {1'b0, nq_s[EW][i]};
			if (neg_s[EW][i]) begin
				if (ovf_s[EW][i] || qmag_c[i] > NEG_LIM) begin
					qmag_c[i] = NEG_LIM;
				end
				qsgn_c[i] = -$signed(qmag_c[i]);
			end else begin
				if (ovf_s[EW][i] || qmag_c[i] > POS_LIM) begin
					qmag_c[i] = POS_LIM;
				end
				qsgn_c[i] = $signed(qmag_c[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			res_q[i] <= sing_s[EW] ? '0 : qsgn_c[i][EW-1:0];
		end
		sing_q <= sing_s[EW];
	end

	assign done     = done_q;
	assign singular = sing_q;
	assign r00 = 32'(res_q[0]);
	assign r01 = 32'(res_q[1]);
	assign r02 = 32'(res_q[2]);
	assign r10 = 32'(res_q[3]);
	assign r11 = 32'(res_q[4]);
	assign r12 = 32'(res_q[5]);
	assign r20 = 32'(res_q[6]);
	assign r21 = 32'(res_q[7]);
	assign r22 = 32'(res_q[8]);
endmodule

@@ src/m3inv_div_step.sv @@
`timescale 1ns / 1ps
// One registered step of a restoring divider lane: shifts in one
// numerator bit and produces one quotient bit. No package dependencies.
module m3inv_div_step #(
	parameter int DMW = 97,
	parameter int EW  = 32
) (
	input  logic           clk,
	input  logic [DMW-1:0] rem_i,
	input  logic [EW-1:0]  nq_i,
	input  logic [DMW-1:0] dmag_i,
	output logic [DMW-1:0] rem_o,
	output logic [EW-1:0]  nq_o
);
	logic [DMW:0] trial;
	logic [DMW:0] diff;
	logic         ge;

	always_comb begin
		trial = {rem_i, nq_i[EW-1]};
		diff  = trial - {1'b0, dmag_i};
		ge    = (trial >= {1'b0, dmag_i});
	end

	// numerator bits leave at the top of nq, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		rem_o <= ge ? diff[DMW-1:0] : trial[DMW-1:0];
		nq_o  <= {nq_i[EW-2:0], ge};
	end
endmodule

@@ tb/mat3_inverse_adjugate_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the 3x3 fixed-point matrix inverse core.
// Depends on m3inv_pkg and mat3_inverse_adjugate_core; self-checking against an in-file predictor.
module mat3_inverse_adjugate_core_tb;
	import m3inv_pkg::*;

	localparam int EW = ELEM_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = EW + 7;

	typedef struct packed {
		logic [8:0][31:0] r;
		logic             sing;
	} inverse_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic [31:0] m [9];
	logic        done;
	logic [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic        singular;

	logic [63:0] threshold = '0;
	inverse_t    inverse_q[$];
	int          errors = 0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          singular_seen = 0;
	int          saturated_seen = 0;

	initial for (int i = 0; i < 9; i++) m[i] = '0;

	always #4 clk = ~clk;

	mat3_inverse_adjugate_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]),
		.m12(m[5]), .m20(m[6]), .m21(m[7]), .m22(m[8]),
		.done(done),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11),
		.r12(r12), .r20(r20), .r21(r21), .r22(r22),
		.singular(singular)
	);

	function automatic logic signed [127:0] sext_elem(logic [31:0] raw);
		logic signed [EW-1:0] v;
		v = raw[EW-1:0];
		return 128'(v);
	endfunction

	// cofactor * 2^(2F) / det, truncated toward zero, saturated
	function automatic logic [31:0] quotient_sat(logic signed [127:0] cof,
			logic signed [127:0] det);
		logic [127:0] cmag, dmag, q;
		logic         neg;
		logic [127:0] lim;
		logic signed [127:0] sq;
		cmag = cof < 0 ? -cof : cof;
		dmag = det < 0 ? -det : det;
		neg = (cof < 0) != (det < 0);
		q = (cmag << (2 * FB)) / dmag;
		lim = (128'd1 << (EW - 1)) - (neg ? 128'd0 : 128'd1);
		if (q > lim) q = lim;
		sq = neg ? -$signed(q) : $signed(q);
		return sq[31:0];
	endfunction

	function automatic inverse_t predict_inverse(logic [31:0] mi [9]);
		logic signed [127:0] e [9];
		logic signed [127:0] cof [9];
		logic signed [127:0] det;
		logic [127:0] dmag;
		inverse_t res;
		for (int i = 0; i < 9; i++) e[i] = sext_elem(mi[i]);
		cof[0] = e[4] * e[8] - e[7] * e[5];
		cof[1] = -(e[1] * e[8] - e[7] * e[2]);
		cof[2] = e[1] * e[5] - e[4] * e[2];
		cof[3] = -(e[3] * e[8] - e[6] * e[5]);
		cof[4] = e[0] * e[8] - e[6] * e[2];
		cof[5] = -(e[0] * e[5] - e[3] * e[2]);
		cof[6] = e[3] * e[7] - e[6] * e[4];
		cof[7] = -(e[0] * e[7] - e[6] * e[1]);
		cof[8] = e[0] * e[4] - e[3] * e[1];
		det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
		dmag = det < 0 ? -det : det;
		res.sing = dmag <= {64'd0, threshold};
		for (int i = 0; i < 9; i++)
			res.r[8 - i] = res.sing ? 32'd0 : quotient_sat(cof[i], det);
		return res;
	endfunction

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		logic [31:0] got [9];
		inverse_t exp_w;
		if (arst_n && done) begin
			got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			if (inverse_q.size() == 0) begin
				$error("result word with no expectation pending");
				errors++;
			end else begin
				exp_w = inverse_q.pop_front();
				words_checked++;
				if (singular !== exp_w.sing) begin
					$error("singular: expected %0b got %0b", exp_w.sing, singular);
					errors++;
				end
				for (int i = 0; i < 9; i++)
					if (got[i] !== exp_w.r[8 - i]) begin
						$error("r%0d%0d: expected %h got %h", i / 3, i % 3,
							exp_w.r[8 - i], got[i]);
						errors++;
					end
			end
		end
	end

	// start stays high into the next word when there is no gap
	task automatic send_matrix(logic [31:0] mi [9]);
		inverse_t p;
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		for (int i = 0; i < 9; i++) m[i] <= mi[i];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		p = predict_inverse(mi);
		inverse_q.push_back(p);
		words_sent++;
		if (p.sing) singular_seen++;
		for (int i = 0; i < 9; i++)
			if (!p.sing && (p.r[i] == 32'h7fffffff || p.r[i] == 32'h80000000))
				saturated_seen++;
	endtask

	task automatic drain_pipe();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (inverse_q.size() != 0 && waited < 10 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_threshold(logic [63:0] v);
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = v;
	endtask

	function automatic logic [31:0] rand_elem(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
			2: return 32'($signed($urandom_range(0, 512)) - 256);
			default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] a [9];
		logic [31:0] one;
		one = 32'd1 << FB;
		a = '{one, 0, 0, 0, one, 0, 0, 0, one};                   send_matrix(a);
		a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                         send_matrix(a);
		a = '{-one, 0, 0, 0, one*2, 0, 0, 0, one/2};              send_matrix(a);
		a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                         send_matrix(a);
		a = '{1, 0, 0, 0, -1, 0, 0, 0, 1};                        send_matrix(a);
		a = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff};
		send_matrix(a);
		a = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
		send_matrix(a);
		for (int i = 0; i < 9; i++) a[i] = 32'h80000000;          send_matrix(a);
		for (int i = 0; i < 9; i++) a[i] = 32'h7fffffff;          send_matrix(a);
		for (int i = 0; i < 9; i++) a[i] = 32'hffffffff;          send_matrix(a);
		a = '{one, one*2, one*3, one*4, one*5, one*6, one*7, one*8, one*10};
		send_matrix(a);
		a = '{one, one*2, one*3, one*2, one*4, one*6, one*7, one*8, one*9};
		send_matrix(a);
		a = '{32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 1};
		send_matrix(a);
		a = '{0, one, 0, 0, 0, one, one, 0, 0};                   send_matrix(a);
		a = '{32'h55555555, 32'haaaaaaaa, 1, 2, 32'h55555555, 3, 32'haaaaaaaa, 4,
			32'h55555555};
		send_matrix(a);
	endtask

	task automatic test_random(int count, int dominant);
		logic [31:0] a [9];
		int mode;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 9; i++) begin
				mode = $urandom_range(0, 9) < 6 ? dominant : $urandom_range(0, 3);
				a[i] = rand_elem(mode);
			end
			send_matrix(a);
		end
	endtask

	task automatic test_threshold_sweep();
		// singular band, near-threshold small matrices, the extreme, then a random threshold
		write_threshold(64'd1 << (3 * FB));
		test_random(120, 1);
		write_threshold(64'd1000);
		test_random(120, 2);
		write_threshold(64'hffffffffffffffff);
		test_random(120, 1);
		write_threshold({$urandom(), $urandom()});
		test_random(100, 0);
		write_threshold(64'd0);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 1);
		test_random(200, 0);
		test_threshold_sweep();
		test_random(80, 3);
		test_random(100, 2);
		drain_pipe();
		$display("Sent %0d matrices, checked %0d; %0d singular, %0d saturated elements",
			words_sent, words_checked, singular_seen, saturated_seen);
		if (errors == 0 && inverse_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
